// ===== rtl/dhs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared constants and codes for the double-hashing set.
// ----------------------------------------------------------------------------
package dhs_pkg;

  localparam int DHS_TABLE_SIZE   = 101;
  localparam int DHS_STEP_MODULUS = 107;

  localparam int KEY_W    = 31;
  localparam int TDATA_W  = 32;
  localparam int RDATA_W  = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic MOD_SEL_TABLE = 1'b0;
  localparam logic MOD_SEL_STEP  = 1'b1;

endpackage : dhs_pkg
`default_nettype wire

// ===== rtl/dhs_mod_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhs_mod_unit
// Remainder by one of two fixed moduli on one shared multiplier.
// ----------------------------------------------------------------------------
module dhs_mod_unit #(
  parameter int TABLE_SIZE   = dhs_pkg::DHS_TABLE_SIZE,
  parameter int STEP_MODULUS = dhs_pkg::DHS_STEP_MODULUS,
  parameter int MOD_W        = 17
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      sel,
  input  wire logic [dhs_pkg::KEY_W-1:0] dividend,
  output logic                           done,
  output logic      [MOD_W-1:0]          rem
);
  import dhs_pkg::*;

  // The quotient is the dividend times a rounded-up reciprocal, shifted
  // down; this is exact for every dividend below 2**KEY_W.
  localparam int MAGIC_W   = KEY_W + 1;
  localparam int PROD_W    = KEY_W + MAGIC_W;
  localparam int TBL_SHIFT = KEY_W + $clog2(TABLE_SIZE);
  localparam int STP_SHIFT = KEY_W + $clog2(STEP_MODULUS);
  localparam logic [63:0] TBL_MAGIC =
    ((64'd1 << TBL_SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
  localparam logic [63:0] STP_MAGIC =
    ((64'd1 << STP_SHIFT) + 64'(STEP_MODULUS - 1)) / 64'(STEP_MODULUS);

  typedef enum logic [1:0] {
    P_IDLE,
    P_RECIP,
    P_BACK,
    P_SUB
  } phase_t;

  phase_t             phase;
  logic               sel_q;
  logic [KEY_W-1:0]   value;
  logic [PROD_W-1:0]  prod;
  logic [KEY_W-1:0]   quot;
  logic [KEY_W-1:0]   mul_a;
  logic [MAGIC_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [KEY_W-1:0]   diff;

  assign quot = (sel_q == MOD_SEL_STEP) ? KEY_W'(prod >> STP_SHIFT) :
                                          KEY_W'(prod >> TBL_SHIFT);

  always_comb begin
    if (phase == P_RECIP) begin
      mul_a = value;
      mul_b = (sel_q == MOD_SEL_STEP) ? STP_MAGIC[MAGIC_W-1:0] : TBL_MAGIC[MAGIC_W-1:0];
    end else begin
      mul_a = quot;
      mul_b = (sel_q == MOD_SEL_STEP) ? MAGIC_W'(STEP_MODULUS) : MAGIC_W'(TABLE_SIZE);
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign diff  = value - prod[KEY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            value <= dividend;
            sel_q <= sel;
            phase <= P_RECIP;
          end
        end
        P_RECIP: begin
          prod  <= mul_p;
          phase <= P_BACK;
        end
        P_BACK: begin
          prod  <= mul_p;
          phase <= P_SUB;
        end
        P_SUB: begin
          rem   <= diff[MOD_W-1:0];
          done  <= 1'b1;
          phase <= P_IDLE;
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule : dhs_mod_unit
`default_nettype wire

// ===== rtl/dhs_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dhs_slot_ram
// Single-port slot memory with registered read data.
// ----------------------------------------------------------------------------
module dhs_slot_ram #(
  parameter int DEPTH  = 101,
  parameter int ADDR_W = 7
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         addr,
  input  wire logic [dhs_pkg::KEY_W-1:0] wdata,
  output logic      [dhs_pkg::KEY_W-1:0] rdata
);
  import dhs_pkg::*;

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : dhs_slot_ram
`default_nettype wire

// ===== rtl/double_hash_set.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_set
// Open-addressed hash set with double hashing over a slot memory.
// ----------------------------------------------------------------------------
// After reset the block clears the slot memory one slot at a time and holds
// s_tready low until that pass is done. It then takes one request at a time
// and is not ready while it works on it. A zero key skips the remainder unit
// and the probes and goes straight to the finish state. Any other key first runs three passes through a shared
// remainder unit (home slot, raw step, step folded into the table), which
// multiplies by a fixed reciprocal and then back by the modulus on one
// multiplier; then each probe of the single-port slot memory passes through
// a read state and then a compare-and-write state, and the result is then
// loaded into the output register. A request makes at most TABLE_SIZE
// probes. A result may wait in the output register while the next request is
// already being worked on; a request that finishes while that result is still
// unaccepted waits for it.
module double_hash_set #(
  parameter int TABLE_SIZE   = dhs_pkg::DHS_TABLE_SIZE,
  parameter int STEP_MODULUS = dhs_pkg::DHS_STEP_MODULUS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [dhs_pkg::TDATA_W-1:0] s_tdata,  // [30:0] key, [31] zero
  input  wire logic                        s_tuser,  // [0] kind
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [dhs_pkg::RDATA_W-1:0] m_tdata   // [0] ok, [7:1] zero
);
  import dhs_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int MAX_M = (TABLE_SIZE > STEP_MODULUS) ? TABLE_SIZE : STEP_MODULUS;
  localparam int MOD_W = $clog2(MAX_M + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WAIT_HOME,
    S_WAIT_STEP,
    S_WAIT_FOLD,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t           state;
  logic [KEY_W-1:0] key_q;
  logic             kind_q;
  logic             ok_q;
  logic             m_ok;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] home;
  logic [IDX_W-1:0] step;

  logic             accept;
  logic [KEY_W-1:0] in_key;
  logic             mod_start;
  logic [KEY_W-1:0] mod_dividend;
  logic             mod_sel;
  logic             mod_done;
  logic [MOD_W-1:0] mod_rem;

  logic             ram_we;
  logic [KEY_W-1:0] ram_wdata;
  logic [KEY_W-1:0] ram_rdata;

  logic [IDX_W:0]   idx_sum;
  logic [IDX_W-1:0] idx_next;
  logic             out_free;

  assign in_key   = s_tdata[KEY_W-1:0];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(RDATA_W-1){1'b0}}, m_ok};

  // Sequencer feeds the shared remainder unit three times per request with a nonzero key.
  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = key_q;
    mod_sel      = MOD_SEL_TABLE;
    case (state)
      S_IDLE: begin
        mod_start    = accept && (in_key != '0);
        mod_dividend = in_key;
      end
      S_WAIT_HOME: begin
        mod_start = mod_done;
        mod_sel   = MOD_SEL_STEP;
      end
      S_WAIT_STEP: begin
        mod_start    = mod_done;
        mod_dividend = {{(KEY_W-MOD_W){1'b0}}, mod_rem};
      end
      default: begin
        mod_start = 1'b0;
      end
    endcase
  end

  dhs_mod_unit #(
    .TABLE_SIZE   (TABLE_SIZE),
    .STEP_MODULUS (STEP_MODULUS),
    .MOD_W        (MOD_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .sel      (mod_sel),
    .dividend (mod_dividend),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // The clearing pass and the probes share the index register as address.
  assign ram_we    = (state == S_CLEAR) ||
                     ((state == S_CHECK) && (kind_q == KIND_INSERT) && (ram_rdata == '0));
  assign ram_wdata = (state == S_CLEAR) ? '0 : key_q;

  dhs_slot_ram #(
    .DEPTH  (TABLE_SIZE),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (idx),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign idx_sum  = {1'b0, idx} + {1'b0, step};
  assign idx_next = (idx_sum >= (IDX_W+1)'(TABLE_SIZE)) ?
                    IDX_W'(idx_sum - (IDX_W+1)'(TABLE_SIZE)) : idx_sum[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (idx == IDX_W'(TABLE_SIZE - 1)) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            key_q  <= in_key;
            kind_q <= s_tuser;
            ok_q   <= 1'b0;
            if (in_key == '0) begin
              state <= S_FINISH;
            end else begin
              state <= S_WAIT_HOME;
            end
          end
        end
        S_WAIT_HOME: begin
          if (mod_done) begin
            home  <= IDX_W'(mod_rem);
            idx   <= IDX_W'(mod_rem);
            state <= S_WAIT_STEP;
          end
        end
        S_WAIT_STEP: begin
          if (mod_done) begin
            state <= S_WAIT_FOLD;
          end
        end
        S_WAIT_FOLD: begin
          if (mod_done) begin
            // A step that folds to zero would never move; use one instead.
            step  <= (mod_rem == '0) ? IDX_W'(1) : IDX_W'(mod_rem);
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (ram_rdata == '0) begin
            ok_q  <= (kind_q == KIND_INSERT);
            state <= S_FINISH;
          end else if ((kind_q == KIND_LOOKUP) && (ram_rdata == key_q)) begin
            ok_q  <= 1'b1;
            state <= S_FINISH;
          end else if (idx_next == home) begin
            state <= S_FINISH;
          end else begin
            idx   <= idx_next;
            state <= S_READ;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_ok     <= ok_q;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule : double_hash_set
`default_nettype wire

// ===== sim/double_hash_set_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_set_tb
// Self-checking bench for the double-hashing set. A small scoreboard keeps
// its own copy of the slot table and predicts the ok flag of every accepted
// request, which is checked against each result in order. Directed requests
// cover zero keys, extreme keys, degenerate steps and collisions. Random
// requests then fill the table and probe it when full.
// ----------------------------------------------------------------------------

class dhs_scoreboard;
  bit [dhs_pkg::KEY_W-1:0] slots [dhs_pkg::DHS_TABLE_SIZE];
  bit                      pending_ok [$];
  int                      errors;

  function new();
    foreach (slots[i]) slots[i] = '0;
    errors = 0;
  endfunction

  // Walks the probe path exactly as the set does and updates the table copy.
  function bit predict_ok(logic kind, bit [dhs_pkg::KEY_W-1:0] key);
    int unsigned home;
    int unsigned stride;
    int unsigned pos;
    bit          ok;
    ok = 1'b0;
    if (key == '0) return 1'b0;
    home   = key % dhs_pkg::DHS_TABLE_SIZE;
    stride = (key % dhs_pkg::DHS_STEP_MODULUS) % dhs_pkg::DHS_TABLE_SIZE;
    if (stride == 0) stride = 1;
    pos = home;
    for (int n = 0; n < dhs_pkg::DHS_TABLE_SIZE; n++) begin
      if (slots[pos] == '0) begin
        if (kind == dhs_pkg::KIND_INSERT) begin
          slots[pos] = key;
          ok = 1'b1;
        end
        break;
      end
      if (kind == dhs_pkg::KIND_LOOKUP && slots[pos] == key) begin
        ok = 1'b1;
        break;
      end
      pos += stride;
      if (pos >= dhs_pkg::DHS_TABLE_SIZE) pos -= dhs_pkg::DHS_TABLE_SIZE;
      if (pos == home) break;
    end
    return ok;
  endfunction

  function bit note_request(logic kind, bit [dhs_pkg::KEY_W-1:0] key);
    bit ok;
    ok = predict_ok(kind, key);
    pending_ok.push_back(ok);
    return ok;
  endfunction

  function void check_result(bit ok);
    bit want;
    if (pending_ok.size() == 0) begin
      $display("%0t: result with no request pending: expected none, actual ok=%0d",
               $time, ok);
      errors++;
      return;
    end
    want = pending_ok.pop_front();
    if (ok !== want) begin
      $display("%0t: ok mismatch: expected %0d, actual %0d", $time, want, ok);
      errors++;
    end
  endfunction

  function int outstanding();
    return pending_ok.size();
  endfunction
endclass

module double_hash_set_tb;
  import dhs_pkg::*;

  localparam int RANDOM_REQUESTS = 400;
  localparam int DRAIN_CYCLES    = 400;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TDATA_W-1:0]  s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RDATA_W-1:0]  m_tdata;

  dhs_scoreboard          sb;
  logic [KEY_W-1:0]       stored_keys [$];

  double_hash_set dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("double_hash_set_tb: done, errors");
    $finish;
  end

  // Holds the request until the set takes it, then records the prediction.
  task automatic send_request(input logic kind, input logic [KEY_W-1:0] key);
    bit ok;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, key};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    ok = sb.note_request(kind, key);
    if (kind == KIND_INSERT && ok) stored_keys.push_back(key);
  endtask

  // Idle gap with junk on the data lines.
  task automatic sender_gap(input int cycles);
    s_tvalid <= 1'b0;
    s_tdata  <= $urandom();
    s_tuser  <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned      r;
    logic [KEY_W-1:0] base;
    r = $urandom_range(0, 99);
    if (r < 45 || stored_keys.size() == 0) begin
      pick_key = KEY_W'($urandom());
      if (pick_key == '0) pick_key = KEY_W'(1);
    end else if (r < 75) begin
      pick_key = KEY_W'($urandom_range(1, 2000));
    end else begin
      // Same home slot as a stored key, usually with a different step.
      base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      pick_key = KEY_W'((base % DHS_TABLE_SIZE)
                        + DHS_TABLE_SIZE * $urandom_range(1, 20_000_000));
    end
  endfunction

  always @(posedge clk) begin
    int unsigned phase;
    int unsigned mode;
    if (m_tvalid && m_tready) sb.check_result(m_tdata[0]);
    phase = 32'($time / 10);
    mode  = (phase / 64) % 4;
    case (mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= ($urandom_range(0, 2) != 0);
      end
      2: begin
        m_tready <= ((phase % 5) < 3);
      end
      default: begin
        m_tready <= ((phase % 16) == 0);
      end
    endcase
  end

  initial begin
    int unsigned burst;
    int unsigned r;
    logic        kind;
    logic [KEY_W-1:0] key;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table, zero keys and extreme keys.
    send_request(KIND_LOOKUP, 31'd1);
    send_request(KIND_INSERT, 31'd0);
    send_request(KIND_LOOKUP, 31'd0);
    send_request(KIND_INSERT, 31'd1);
    send_request(KIND_LOOKUP, 31'd1);
    send_request(KIND_INSERT, 31'h7FFF_FFFF);
    send_request(KIND_LOOKUP, 31'h7FFF_FFFF);
    // Keys whose step folds to zero and falls back to one.
    send_request(KIND_INSERT, 31'd107);
    send_request(KIND_INSERT, 31'd101);
    send_request(KIND_INSERT, 31'd208);
    send_request(KIND_INSERT, 31'd214);
    send_request(KIND_LOOKUP, 31'd208);
    // A chain of keys sharing one home slot.
    send_request(KIND_INSERT, 31'd5);
    send_request(KIND_INSERT, 31'd106);
    send_request(KIND_INSERT, 31'd207);
    send_request(KIND_LOOKUP, 31'd207);
    send_request(KIND_LOOKUP, 31'd308);
    // Duplicates are stored again.
    send_request(KIND_INSERT, 31'd5);
    send_request(KIND_LOOKUP, 31'd5);
    send_request(KIND_INSERT, 31'h5555_5555);
    send_request(KIND_INSERT, 31'h2AAA_AAAA);
    send_request(KIND_LOOKUP, 31'h2AAA_AAAA);
    send_request(KIND_LOOKUP, 31'h5555_5554);
    sender_gap(3);

    // Random bursts of inserts, lookups and zero keys; the table fills and is then probed full.
    for (int i = 0; i < RANDOM_REQUESTS; ) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && i < RANDOM_REQUESTS; b++, i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          kind = KIND_INSERT;
          key  = pick_key();
        end else if (r < 85) begin
          kind = KIND_LOOKUP;
          if (stored_keys.size() != 0 && $urandom_range(0, 1))
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          else
            key = pick_key();
        end else if (r < 90) begin
          kind = 1'($urandom_range(0, 1));
          key  = '0;
        end else begin
          kind = KIND_INSERT;
          if (stored_keys.size() != 0)
            key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          else
            key = pick_key();
        end
        send_request(kind, key);
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 8));
    end

    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("double_hash_set_tb: done, clean");
    end else begin
      $display("double_hash_set_tb: done, errors");
    end
    $finish;
  end

endmodule
